// File: rtl/sacc_pkg.sv
// Shared opcodes, status codes and register indexes of the saturating accumulator.
`default_nettype none
package sacc_pkg;
    localparam int MODE_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_LOAD  = 4'd0;
    localparam t_mode MODE_CLEAR = 4'd1;
    localparam t_mode MODE_ADD   = 4'd2;
    localparam t_mode MODE_SUB   = 4'd3;
    localparam t_mode MODE_MUL   = 4'd4;
    localparam t_mode MODE_DIV   = 4'd5;
    localparam t_mode MODE_SQRT  = 4'd6;
    localparam t_mode MODE_READ  = 4'd7;
    localparam t_mode MODE_RANGE = 4'd8;

    localparam t_status STATUS_OK      = 2'd0;
    localparam t_status STATUS_DIV0    = 2'd1;
    localparam t_status STATUS_SQRTNEG = 2'd2;

    localparam t_cfg_idx CFG_LOWER = 1'b0;
    localparam t_cfg_idx CFG_UPPER = 1'b1;
endpackage
`default_nettype wire

// File: rtl/sacc_clamp.sv
// Clamps a wide signed value into the range given by two word-wide limits.
`default_nettype none
module sacc_clamp #(
    parameter int IN_W  = 64,
    parameter int OUT_W = 32
) (
    input  wire logic signed [IN_W-1:0]  i_val,
    input  wire logic signed [OUT_W-1:0] i_lo,
    input  wire logic signed [OUT_W-1:0] i_hi,
    output logic signed [OUT_W-1:0]      o_val
);
    logic signed [IN_W-1:0] lo_ext;
    logic signed [IN_W-1:0] hi_ext;

    assign lo_ext = IN_W'(i_lo);
    assign hi_ext = IN_W'(i_hi);

    always_comb begin
        if (i_val < lo_ext) begin
            o_val = i_lo;
        end else if (i_val > hi_ext) begin
            o_val = i_hi;
        end else begin
            o_val = i_val[OUT_W-1:0];
        end
    end
endmodule
`default_nettype wire

// File: rtl/saturating_accumulator_alu_unit.sv
// Top level of the saturating fixed-point accumulator with bit-serial arithmetic.
`default_nettype none
// A saturating accumulator in signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction bits). Each input word carries an opcode and an operand and yields
// exactly one result word. Load, clear, add, subtract, read, range check and
// the two error cases pass through S_PRE and S_CLAMP to the output register;
// multiply (one multiplier bit per cycle), divide (one quotient bit per
// cycle) and square root (one root bit per cycle) pass through S_PRE, their
// bit-serial state, S_FIX and S_CLAMP. One word is worked on at a time; a new
// word is accepted once the previous result sits in the output register, even
// if it has not been taken yet. A full output register holds the finished
// word until the register is taken. Limit writes take effect for the next
// accepted word.
module saturating_accumulator_alu_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire sacc_pkg::t_mode               i_mode,
    input  wire logic signed [WORD_BITS-1:0]   i_operand,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [WORD_BITS-1:0]        o_result_value,
    output sacc_pkg::t_status                  o_status,
    output logic                               o_in_range,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire sacc_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic signed [WORD_BITS-1:0]   i_cfg_data
);
    import sacc_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int ND  = W + F;
    localparam int N2  = (ND + 1) / 2;
    localparam int SW  = 2 * N2;
    localparam int VW  = 2 * W + F + 2;
    localparam int CW  = $clog2(ND + 1);
    localparam logic [CW-1:0] CNT_MUL  = CW'(W);
    localparam logic [CW-1:0] CNT_DIV  = CW'(ND);
    localparam logic [CW-1:0] CNT_SQRT = CW'(N2);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_PRE, S_MUL, S_DIV, S_SQRT, S_FIX, S_CLAMP
    } t_state;

    t_state                r_state;
    t_mode                 r_mode;
    logic signed [W-1:0]   r_opnd;
    logic signed [W-1:0]   r_lower, r_upper;
    logic signed [W-1:0]   r_lo, r_hi;
    logic signed [W-1:0]   r_acc;
    logic                  r_neg;
    logic [CW-1:0]         r_cnt;
    logic [2*W-1:0]        r_sum;
    logic [2*W-1:0]        r_mcand;
    logic [W-1:0]          r_mplier;
    logic [ND-1:0]         r_num;
    logic [W-1:0]          r_rem;
    logic [SW-1:0]         r_sq;
    logic [N2-1:0]         r_root;
    logic [N2+1:0]         r_srem;
    logic signed [VW-1:0]  r_v;
    t_status               r_status;
    logic                  r_inr;
    logic                  r_out_valid;
    logic signed [W-1:0]   r_res;
    t_status               r_ostat;
    logic                  r_oinr;

    logic signed [W-1:0]   pre_acc;
    logic signed [W-1:0]   post_val;
    logic [W-1:0]          mag_a, mag_b;
    logic [W:0]            div_sh;
    logic                  div_ge;
    logic [N2+1:0]         sq_sh, sq_trial;
    logic                  sq_ge;
    logic signed [VW-1:0]  fix_mag, fix_sgn;
    logic                  out_free;

    sacc_clamp #(.IN_W(W), .OUT_W(W)) u_pre_clamp (
        .i_val (r_acc),
        .i_lo  (r_lo),
        .i_hi  (r_hi),
        .o_val (pre_acc)
    );

    sacc_clamp #(.IN_W(VW), .OUT_W(W)) u_post_clamp (
        .i_val (r_v),
        .i_lo  (r_lo),
        .i_hi  (r_hi),
        .o_val (post_val)
    );

    assign mag_a = pre_acc[W-1] ? W'(-pre_acc) : W'(pre_acc);
    assign mag_b = r_opnd[W-1] ? W'(-r_opnd) : W'(r_opnd);

    assign div_sh = {r_rem, r_num[ND-1]};
    assign div_ge = div_sh >= {1'b0, r_mplier};

    assign sq_sh    = {r_srem[N2-1:0], r_sq[SW-1:SW-2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    always_comb begin
        if (r_mode == MODE_MUL) begin
            fix_mag = VW'(r_sum);
        end else begin
            fix_mag = VW'(r_num);
        end
        fix_sgn = r_neg ? -fix_mag : fix_mag;
    end

    assign out_free       = !r_out_valid || i_out_ready;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_res;
    assign o_status       = r_ostat;
    assign o_in_range     = r_oinr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lower     <= {1'b1, {(W-1){1'b0}}};
            r_upper     <= {1'b0, {(W-1){1'b1}}};
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LOWER: r_lower <= i_cfg_data;
                    CFG_UPPER: r_upper <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode <= i_mode;
                        r_opnd <= i_operand;
                        r_lo   <= (r_lower < r_upper) ? r_lower : r_upper;
                        r_hi   <= (r_lower < r_upper) ? r_upper : r_lower;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_acc    <= pre_acc;
                    r_status <= STATUS_OK;
                    r_inr    <= 1'b0;
                    r_v      <= VW'(pre_acc);
                    r_neg    <= pre_acc[W-1] ^ r_opnd[W-1];
                    r_state  <= S_CLAMP;
                    case (r_mode)
                        MODE_LOAD:  r_v <= VW'(r_opnd);
                        MODE_CLEAR: r_v <= '0;
                        MODE_ADD:   r_v <= VW'(pre_acc) + VW'(r_opnd);
                        MODE_SUB:   r_v <= VW'(pre_acc) - VW'(r_opnd);
                        MODE_MUL: begin
                            r_mcand  <= (2*W)'(mag_a);
                            r_mplier <= mag_b;
                            r_sum    <= '0;
                            r_cnt    <= CNT_MUL;
                            r_state  <= S_MUL;
                        end
                        MODE_DIV: begin
                            if (r_opnd == '0) begin
                                r_status <= STATUS_DIV0;
                            end else begin
                                r_num    <= ND'(mag_a) << F;
                                r_rem    <= '0;
                                r_mplier <= mag_b;
                                r_cnt    <= CNT_DIV;
                                r_state  <= S_DIV;
                            end
                        end
                        MODE_SQRT: begin
                            if (pre_acc[W-1]) begin
                                r_status <= STATUS_SQRTNEG;
                            end else begin
                                r_sq    <= SW'(mag_a) << F;
                                r_root  <= '0;
                                r_srem  <= '0;
                                r_cnt   <= CNT_SQRT;
                                r_state <= S_SQRT;
                            end
                        end
                        MODE_RANGE: r_inr <= (r_opnd >= r_lo) && (r_opnd <= r_hi);
                        default: ;
                    endcase
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_sum <= r_sum + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - CNT_ONE;
                    if (r_cnt == CNT_ONE) begin
                        r_state <= S_FIX;
                    end
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= W'(div_sh - {1'b0, r_mplier});
                    end else begin
                        r_rem <= div_sh[W-1:0];
                    end
                    r_num <= {r_num[ND-2:0], div_ge};
                    r_cnt <= r_cnt - CNT_ONE;
                    if (r_cnt == CNT_ONE) begin
                        r_state <= S_FIX;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_srem <= sq_sh - sq_trial;
                        r_root <= {r_root[N2-2:0], 1'b1};
                    end else begin
                        r_srem <= sq_sh;
                        r_root <= {r_root[N2-2:0], 1'b0};
                    end
                    r_sq  <= r_sq << 2;
                    r_cnt <= r_cnt - CNT_ONE;
                    if (r_cnt == CNT_ONE) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // Signed product is floored by the arithmetic shift.
                    if (r_mode == MODE_SQRT) begin
                        r_v <= VW'(r_root);
                    end else if (r_mode == MODE_MUL) begin
                        r_v <= fix_sgn >>> F;
                    end else begin
                        r_v <= fix_sgn;
                    end
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_acc <= post_val;
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_res       <= post_val;
                        r_ostat     <= r_status;
                        r_oinr      <= r_inr;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: bench/saturating_accumulator_alu_unit_tb.sv
// Self-checking testbench of the saturating fixed-point accumulator.
`default_nettype none
class sacc_scoreboard;
    logic signed [31:0] lower_lim;
    logic signed [31:0] upper_lim;
    logic signed [31:0] acc_value;
    logic signed [31:0] want_value[$];
    sacc_pkg::t_status  want_status[$];
    logic               want_range[$];
    int                 error_count;

    function new();
        lower_lim = 32'sh8000_0000;
        upper_lim = 32'sh7fff_ffff;
        acc_value = 0;
        error_count = 0;
    endfunction

    function longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function longint floor_root(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function void note_item(sacc_pkg::t_mode mode, logic signed [31:0] operand);
        longint lo, hi, a, x, p;
        sacc_pkg::t_status st;
        logic inr;
        lo = (lower_lim < upper_lim) ? lower_lim : upper_lim;
        hi = (lower_lim < upper_lim) ? upper_lim : lower_lim;
        x = operand;
        a = clamp_to(acc_value, lo, hi);
        acc_value = a;
        st = sacc_pkg::STATUS_OK;
        inr = 1'b0;
        case (mode)
            sacc_pkg::MODE_LOAD:  acc_value = clamp_to(x, lo, hi);
            sacc_pkg::MODE_CLEAR: acc_value = clamp_to(0, lo, hi);
            sacc_pkg::MODE_ADD:   acc_value = clamp_to(a + x, lo, hi);
            sacc_pkg::MODE_SUB:   acc_value = clamp_to(a - x, lo, hi);
            sacc_pkg::MODE_MUL: begin
                p = a * x;
                acc_value = clamp_to(p >>> 16, lo, hi);
            end
            sacc_pkg::MODE_DIV: begin
                if (x == 0) st = sacc_pkg::STATUS_DIV0;
                else acc_value = clamp_to((a * 65536) / x, lo, hi);
            end
            sacc_pkg::MODE_SQRT: begin
                if (a < 0) st = sacc_pkg::STATUS_SQRTNEG;
                else acc_value = clamp_to(floor_root(a * 65536), lo, hi);
            end
            sacc_pkg::MODE_RANGE: inr = (x >= lo && x <= hi);
            default: ;
        endcase
        want_value.push_back(acc_value);
        want_status.push_back(st);
        want_range.push_back(inr);
    endfunction

    function void check_result(logic signed [31:0] v, sacc_pkg::t_status st, logic inr);
        logic signed [31:0] ev;
        sacc_pkg::t_status es;
        logic er;
        if (want_value.size() == 0) begin
            $display("%0t: unexpected word value %0d", $time, v);
            error_count++;
            return;
        end
        ev = want_value.pop_front();
        es = want_status.pop_front();
        er = want_range.pop_front();
        if (v !== ev) begin
            $display("%0t: value expected %0d actual %0d", $time, ev, v);
            error_count++;
        end
        if (st !== es) begin
            $display("%0t: status expected %0d actual %0d", $time, es, st);
            error_count++;
        end
        if (inr !== er) begin
            $display("%0t: in_range expected %0d actual %0d", $time, er, inr);
            error_count++;
        end
    endfunction
endclass

module saturating_accumulator_alu_unit_tb;
    import sacc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_mode              mode;
    logic signed [31:0] operand;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result_value;
    t_status            status;
    logic               in_range;
    logic               cfg_valid;
    logic               cfg_ready;
    t_cfg_idx           cfg_index;
    logic signed [31:0] cfg_data;

    sacc_scoreboard     acc_board;
    bit                 sender_done;
    bit                 hold_ready;
    int                 idle_cycles;
    int                 stall_left;

    saturating_accumulator_alu_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (mode),
        .i_operand      (operand),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_value (result_value),
        .o_status       (status),
        .o_in_range     (in_range),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            1: return $signed($urandom_range(0, 8)) <<< 16;
            2: return -($signed($urandom_range(0, 8)) <<< 16);
            3: return $signed($urandom_range(0, 65535)) - 32768;
            4: return 0;
            default: return $urandom();
        endcase
    endfunction

    // Valid stays high into the next word when no gap follows an accepted word.
    task automatic send_word(t_mode m, logic signed [31:0] x);
        int gap;
        gap = gap_length();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        operand  <= x;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        acc_board.note_item(m, x);
    endtask

    // Waits until every result has been taken and the datapath has drained.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (acc_board.want_value.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_limit(t_cfg_idx idx, logic signed [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_LOWER) acc_board.lower_lim = data;
        else acc_board.upper_lim = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_word(t_mode'($urandom_range(0, 15) < 14 ? $urandom_range(0, 8)
                                                         : $urandom_range(9, 15)),
                      random_operand());
        end
    endtask

    // Receiver: random stalls, mostly short and now and then long.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready)
                acc_board.check_result(result_value, status, in_range);
            if (hold_ready) begin
                out_ready <= 1'b1;
            end else if (stall_left != 0) begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end else if ($urandom_range(0, 99) < 3) begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(10, 60);
            end else begin
                out_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int k;
        acc_board   = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_READ;
        operand     = 0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_LOWER;
        cfg_data    = 0;
        hold_ready  = 1'b0;
        sender_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every opcode, extreme operands, errors and unused opcodes.
        send_word(MODE_SQRT, 0);
        send_word(MODE_LOAD, 32'sh7fff_ffff);
        send_word(MODE_ADD, 32'sh7fff_ffff);
        send_word(MODE_MUL, 32'sh7fff_ffff);
        send_word(MODE_SQRT, 0);
        send_word(MODE_DIV, 0);
        send_word(MODE_DIV, 32'sh0000_8000);
        send_word(MODE_LOAD, 32'sh8000_0000);
        send_word(MODE_SUB, 32'sh7fff_ffff);
        send_word(MODE_SQRT, 0);
        send_word(MODE_MUL, 32'sh8000_0000);
        send_word(MODE_LOAD, -32'sd3);
        send_word(MODE_MUL, 32'sd5);
        send_word(MODE_DIV, -32'sd7);
        send_word(MODE_DIV, 32'sh8000_0000);
        send_word(MODE_CLEAR, 32'sh1234_5678);
        send_word(MODE_READ, -1);
        send_word(MODE_RANGE, 32'sh8000_0000);
        send_word(MODE_RANGE, 32'sh7fff_ffff);
        send_word(t_mode'(4'd9), 0);
        send_word(t_mode'(4'd15), -1);
        wait_drained();

        // Limits in the right order, swapped, equal, the extremes and random values.
        write_limit(CFG_LOWER, -32'sd5 <<< 16);
        write_limit(CFG_UPPER, 32'sd7 <<< 16);
        send_word(MODE_CLEAR, 0);
        send_word(MODE_RANGE, 32'sd7 <<< 16);
        send_word(MODE_RANGE, (32'sd7 <<< 16) + 1);
        run_random(400);
        wait_drained();
        write_limit(CFG_LOWER, 32'sd100 <<< 16);
        write_limit(CFG_UPPER, 32'sd3 <<< 16);
        run_random(400);
        wait_drained();
        write_limit(CFG_LOWER, 32'sd2 <<< 16);
        write_limit(CFG_UPPER, 32'sd2 <<< 16);
        run_random(100);
        wait_drained();
        write_limit(CFG_LOWER, 32'sh7fff_ffff);
        write_limit(CFG_UPPER, 32'sh8000_0000);
        run_random(400);
        wait_drained();
        for (k = 0; k < 3; k++) begin
            write_limit(CFG_LOWER, $urandom());
            write_limit(CFG_UPPER, $urandom());
            run_random(150);
            wait_drained();
        end
        hold_ready = 1'b1;
        write_limit(CFG_UPPER, 32'sh7fff_ffff);
        write_limit(CFG_LOWER, 32'sh8000_0000);
        run_random(200);
        wait_drained();
        sender_done = 1'b1;
        if (acc_board.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        if (!sender_done) begin
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule
`default_nettype wire

// File: filelist.f
rtl/sacc_pkg.sv
rtl/sacc_clamp.sv
rtl/saturating_accumulator_alu_unit.sv
bench/saturating_accumulator_alu_unit_tb.sv
